@@ design/cid_width_run_encoder_defines.svh @@
// Assertion helpers for the encoder modules, used by cid_queue.
// Both expect clk and arst_n in scope.
`ifndef CID_WIDTH_RUN_ENCODER_DEFINES_SVH
`define CID_WIDTH_RUN_ENCODER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CID_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define CID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/cid_pkg.sv @@
`default_nettype none
package cid_pkg;

	localparam int MAX_TOK = 6;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		TK_RANGE_FIRST = 3'd0,
		TK_RANGE_LAST  = 3'd1,
		TK_RANGE_WIDTH = 3'd2,
		TK_ARRAY_START = 3'd3,
		TK_ARRAY_WIDTH = 3'd4,
		TK_ARRAY_END   = 3'd5
	} token_kind_t;

	typedef struct packed {
		logic [15:0] code;
		logic [15:0] glyph_width;
		logic        table_end;
	} cid_in_t;

	typedef struct packed {
		token_kind_t token_kind;
		logic [15:0] token_value;
		logic        run_last;
	} cid_out_t;

	typedef struct packed {
		token_kind_t kind;
		logic [15:0] value;
	} tok_t;

	// All tokens caused by one transaction, in emission order from index 0.
	typedef struct packed {
		logic [2:0]              n;
		tok_t [MAX_TOK-1:0]      tok;
	} tok_list_t;

	function automatic tok_list_t put_tok(tok_list_t l, token_kind_t k, logic [15:0] v);
		tok_list_t r;
		r = l;
		if (l.n < 3'(MAX_TOK)) begin
			r.tok[l.n].kind  = k;
			r.tok[l.n].value = v;
			r.n              = l.n + 3'd1;
		end
		return r;
	endfunction

	// Close the open run: finish an array, a lone code as a one-width array, or a range.
	function automatic tok_list_t flush_run(tok_list_t l, logic array_open, logic lone,
			logic [15:0] first_code, logic [15:0] last_code, logic [15:0] width);
		tok_list_t r;
		r = l;
		if (array_open) begin
			r = put_tok(r, TK_ARRAY_WIDTH, width);
			r = put_tok(r, TK_ARRAY_END, 16'd0);
		end else if (lone) begin
			r = put_tok(r, TK_ARRAY_START, first_code);
			r = put_tok(r, TK_ARRAY_WIDTH, width);
			r = put_tok(r, TK_ARRAY_END, 16'd0);
		end else begin
			r = put_tok(r, TK_RANGE_FIRST, first_code);
			r = put_tok(r, TK_RANGE_LAST, last_code);
			r = put_tok(r, TK_RANGE_WIDTH, width);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/cid_front.sv @@
`default_nettype none
module cid_front #(
	parameter int CODE_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  cid_pkg::cid_in_t      item,
	input  wire                   item_valid,
	output logic                  item_ready,
	input  wire                   full,
	output logic                  push,
	output cid_pkg::tok_list_t    push_data
);
	import cid_pkg::*;

	localparam int CW = (CODE_BITS < 16) ? CODE_BITS : 16;

	logic          active_q, aopen_q;
	logic [CW-1:0] start_q;
	logic [15:0]   width_q;
	logic [CW:0]   count_q;

	logic          active_n, aopen_n;
	logic [CW-1:0] start_n;
	logic [15:0]   width_n;
	logic [CW:0]   count_n;
	logic [CW-1:0] code_m;
	logic [CW:0]   next_code;
	logic [CW:0]   last_cur;
	logic [CW:0]   last_new;
	tok_list_t     toks;
	logic          accept;

	assign item_ready = !full;
	assign accept     = item_valid && item_ready;
	assign code_m     = item.code[CW-1:0];
	assign next_code  = {1'b0, start_q} + count_q;
	assign last_cur   = next_code - (CW+1)'(1);

	always_comb begin
		toks     = '0;
		active_n = active_q;
		aopen_n  = aopen_q;
		start_n  = start_q;
		width_n  = width_q;
		count_n  = count_q;
		last_new = '0;
		if (!active_q) begin
			active_n = 1'b1;
			start_n  = code_m;
			width_n  = item.glyph_width;
			count_n  = (CW+1)'(1);
			aopen_n  = 1'b0;
		end else if ({1'b0, code_m} != next_code) begin
			// gap (or non-rising code): close the run, start afresh
			toks    = flush_run(toks, aopen_q, count_q == (CW+1)'(1), 16'(start_q),
					16'(last_cur[CW-1:0]), width_q);
			start_n = code_m;
			width_n = item.glyph_width;
			count_n = (CW+1)'(1);
			aopen_n = 1'b0;
		end else if (item.glyph_width != width_q) begin
			if (count_q != (CW+1)'(1) && !aopen_q) begin
				toks    = put_tok(toks, TK_RANGE_FIRST, 16'(start_q));
				toks    = put_tok(toks, TK_RANGE_LAST, 16'(last_cur[CW-1:0]));
				toks    = put_tok(toks, TK_RANGE_WIDTH, width_q);
				start_n = code_m;
				width_n = item.glyph_width;
				count_n = (CW+1)'(1);
			end else begin
				if (!aopen_q) begin
					toks    = put_tok(toks, TK_ARRAY_START, 16'(start_q));
					aopen_n = 1'b1;
				end
				toks    = put_tok(toks, TK_ARRAY_WIDTH, width_q);
				width_n = item.glyph_width;
				count_n = count_q + (CW+1)'(1);
			end
		end else if (aopen_q) begin
			// equal width ends the array; previous code opens a range
			toks    = put_tok(toks, TK_ARRAY_END, 16'd0);
			aopen_n = 1'b0;
			start_n = last_cur[CW-1:0];
			count_n = (CW+1)'(2);
		end else begin
			count_n = count_q + (CW+1)'(1);
		end

		if (item.table_end) begin
			last_new = {1'b0, start_n} + count_n - (CW+1)'(1);
			toks     = flush_run(toks, aopen_n, count_n == (CW+1)'(1), 16'(start_n),
					16'(last_new[CW-1:0]), width_n);
			active_n = 1'b0;
			aopen_n  = 1'b0;
			start_n  = '0;
			width_n  = '0;
			count_n  = '0;
		end
	end

	assign push      = accept && (toks.n != 3'd0);
	assign push_data = toks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			aopen_q  <= 1'b0;
			start_q  <= '0;
			width_q  <= '0;
			count_q  <= '0;
		end else if (accept) begin
			active_q <= active_n;
			aopen_q  <= aopen_n;
			start_q  <= start_n;
			width_q  <= width_n;
			count_q  <= count_n;
		end
	end

endmodule
`default_nettype wire

@@ design/cid_queue.sv @@
`default_nettype none
`include "cid_width_run_encoder_defines.svh"
module cid_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  cid_pkg::tok_list_t  push_data,
	output logic                full,
	input  wire                 pop,
	output cid_pkg::tok_list_t  head,
	output logic                head_valid
);
	import cid_pkg::*;

	tok_list_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = cnt_q == QCNT_W'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	`CID_ASSERT(a_no_push_full, !(push && full), "push into full queue")
	`CID_ASSERT(a_no_pop_empty, !(pop && !head_valid), "pop from empty queue")
	`CID_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + QCNT_W'(1), "count lost a push")

endmodule
`default_nettype wire

@@ design/cid_back.sv @@
`default_nettype none
module cid_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cid_pkg::tok_list_t  head,
	input  wire                 head_valid,
	output logic                pop,
	output cid_pkg::cid_out_t   token,
	output logic                token_valid,
	input  wire                 token_ready
);
	import cid_pkg::*;

	logic [2:0] idx_q;
	logic       valid_q;
	cid_out_t   tok_q;
	logic       load;
	logic       last_of_entry;

	assign load          = head_valid && (!valid_q || token_ready);
	assign last_of_entry = idx_q == (head.n - 3'd1);
	assign pop           = load && last_of_entry;
	assign token         = tok_q;
	assign token_valid   = valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q.token_kind  <= head.tok[idx_q].kind;
			tok_q.token_value <= head.tok[idx_q].value;
			tok_q.run_last    <= last_of_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last_of_entry ? 3'd0 : idx_q + 3'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (token_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/cid_width_run_encoder.sv @@
// With the queue empty, the first token of a transaction is written into the queue at
//   acceptance, then registered in the output register, from which it can be taken.
// Throughput: one input transaction per cycle while the token queue has room; tokens
//   leave at one per cycle while token_ready is high.
// The four-entry token queue between front and back sets how far input may run ahead.
// Reset (arst_n low, asynchronous): run state cleared, queue empty, no token valid.
`default_nettype none
module cid_width_run_encoder #(
	parameter int CODE_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	// input transactions: (code, width, table_end)
	input  cid_pkg::cid_in_t   item,
	input  wire                item_valid,
	output logic               item_ready,
	// output transactions: width array tokens
	output cid_pkg::cid_out_t  token,
	output logic               token_valid,
	input  wire                token_ready
);
	import cid_pkg::*;

	logic      q_full;
	logic      q_push;
	tok_list_t q_push_data;
	logic      q_pop;
	tok_list_t q_head;
	logic      q_head_valid;

	// Front: tracks the open run and turns each transaction into its token list
	// combinationally. The run state updates at acceptance, so the next item may
	// follow at once; only a full queue holds it off.
	cid_front #(
		.CODE_BITS(CODE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.full       (q_full),
		.push       (q_push),
		.push_data  (q_push_data)
	);

	// Queue of token lists; items that cause no token are never queued.
	cid_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid)
	);

	// Back: walks the head list one token per cycle, as token_ready allows, into
	// the output register, marking the final token of each list with run_last.
	cid_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.head_valid  (q_head_valid),
		.pop         (q_pop),
		.token       (token),
		.token_valid (token_valid),
		.token_ready (token_ready)
	);

endmodule
`default_nettype wire
